// File: src/umx_pkg.sv
// ----------------------------------------------------------------------------
// umx_pkg
// Shared types and codes for the universal machine instruction executor.
// ----------------------------------------------------------------------------
package umx_pkg;

  localparam int NumRegs = 8;
  localparam int RegIdxW = $clog2(NumRegs);
  localparam int WordW = 32;

  // request kinds on the result channel
  typedef enum logic [3:0] {
    K_NONE     = 4'd0,
    K_LOAD     = 4'd1,
    K_STORE    = 4'd2,
    K_MAP      = 4'd3,
    K_UNMAP    = 4'd4,
    K_OUTPUT   = 4'd5,
    K_INPUT    = 4'd6,
    K_LOADPROG = 4'd7,
    K_HALT     = 4'd8,
    K_BADOP    = 4'd9,
    K_DIVZERO  = 4'd10
  } kind_t;

  // pending request kinds, equal to the matching item type
  typedef enum logic [1:0] {
    P_NONE  = 2'd0,
    P_LOAD  = 2'd1,
    P_MAP   = 2'd2,
    P_INPUT = 2'd3
  } pend_t;

  // item types
  localparam logic [1:0] T_INSN = 2'd0;

  // opcodes
  typedef enum logic [3:0] {
    OP_CMOV = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_ADD = 4'd3,
    OP_MUL = 4'd4, OP_DIV = 4'd5, OP_NAND = 4'd6, OP_HALT = 4'd7,
    OP_MAP = 4'd8, OP_UNMAP = 4'd9, OP_OUT = 4'd10, OP_IN = 4'd11,
    OP_LOADP = 4'd12, OP_LOADI = 4'd13, OP_BAD0 = 4'd14, OP_BAD1 = 4'd15
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_OUT
  } state_t;

  // control from sequencer to the shared arithmetic unit
  typedef struct packed {
    logic start_mul;
    logic start_div;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
  } alu_sts_t;

endpackage

// File: src/umx_muldiv.sv
// ----------------------------------------------------------------------------
// umx_muldiv
// Shared shift/add unit: one bit a cycle for multiply (low word) and
// restoring unsigned divide.
// ----------------------------------------------------------------------------
module umx_muldiv (
  input  logic                          clk,
  input  logic                          rst,
  input  umx_pkg::alu_ctl_t             ctl,
  input  logic [umx_pkg::WordW-1:0]     op_b,
  input  logic [umx_pkg::WordW-1:0]     op_c,
  output umx_pkg::alu_sts_t             sts,
  output logic [umx_pkg::WordW-1:0]     res
);

  localparam int CntW = $clog2(umx_pkg::WordW) + 1;

  logic                       busy;
  logic                       is_div;
  logic [CntW-1:0]            cnt;
  logic [umx_pkg::WordW-1:0]  acc;      // product or remainder
  logic [umx_pkg::WordW-1:0]  mq;       // multiplier or dividend/quotient
  logic [umx_pkg::WordW-1:0]  mcand;    // multiplicand or divisor
  logic [umx_pkg::WordW:0]    trial;

  // divide trial subtract, one per cycle while busy; the multiply uses its own add
  assign trial = {acc, mq[umx_pkg::WordW-1]} - {1'b0, mcand};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start_mul || ctl.start_div) begin
      busy   <= 1'b1;
      is_div <= ctl.start_div;
      cnt    <= CntW'(umx_pkg::WordW);
      acc    <= '0;
      mq     <= ctl.start_div ? op_b : op_c;
      mcand  <= ctl.start_div ? op_c : op_b;
    end else if (busy) begin
      if (is_div) begin
        // restoring division step
        if (!trial[umx_pkg::WordW]) begin
          acc <= trial[umx_pkg::WordW-1:0];
          mq  <= {mq[umx_pkg::WordW-2:0], 1'b1};
        end else begin
          acc <= {acc[umx_pkg::WordW-2:0], mq[umx_pkg::WordW-1]};
          mq  <= {mq[umx_pkg::WordW-2:0], 1'b0};
        end
      end else begin
        // shift-add multiply, low word only
        acc   <= mq[0] ? acc + mcand : acc;
        mq    <= {1'b0, mq[umx_pkg::WordW-1:1]};
        mcand <= {mcand[umx_pkg::WordW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  assign sts.busy = busy;
  assign res = is_div ? mq : acc;

  a_busy_counts: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("busy with zero count");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (ctl.start_mul || ctl.start_div) |=> busy) else $error("start did not run");
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    !(ctl.start_mul && ctl.start_div)) else $error("two starts");

endmodule

// File: src/um_instruction_executor.sv
// ----------------------------------------------------------------------------
// um_instruction_executor
// Executes one universal machine instruction or return word per request.
//
//   channel  direction  handshake         fields
//   in       to block   in_valid/in_stall req_type instruction return_value
//                                         end_of_input
//   out      from block out_valid/out_stall req_kind seg_id word_offset
//                                         data_value next_pc
//
// Most requests pass through accept, decode/execute and the result register.
// Multiply, and divide by a nonzero divisor, also use the shared one-bit-a-cycle unit.
// Reset clears the registers, pc and pending request; no clearing pass.
// While a result waits under out_stall the block takes no new request.
// ----------------------------------------------------------------------------
module um_instruction_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] instruction,
  input  logic [31:0] return_value,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  req_kind,
  output logic [31:0] seg_id,
  output logic [31:0] word_offset,
  output logic [31:0] data_value,
  output logic [31:0] next_pc
);

  localparam int W = umx_pkg::WordW;
  localparam int RW = umx_pkg::RegIdxW;

  umx_pkg::state_t state, state_next;
  logic [W-1:0] regs [umx_pkg::NumRegs];
  logic [W-1:0] pc;
  logic [RW-1:0] pending_dest;
  umx_pkg::pend_t pending_kind;

  // captured request
  logic [1:0]  q_type;
  logic [31:0] q_insn;
  logic [31:0] q_rval;
  logic        q_eoi;

  umx_pkg::alu_ctl_t ctl;
  umx_pkg::alu_sts_t sts;
  logic [W-1:0] alu_res;

  umx_pkg::op_t op;
  logic [RW-1:0] ia, ib, ic, il;
  logic [W-1:0] ra, rb, rc;

  assign op = umx_pkg::op_t'(q_insn[31:28]);
  assign ia = q_insn[8:6];
  assign ib = q_insn[5:3];
  assign ic = q_insn[2:0];
  assign il = q_insn[27:25];
  assign ra = regs[ia];
  assign rb = regs[ib];
  assign rc = regs[ic];

  umx_muldiv u_muldiv (
    .clk(clk), .rst(rst), .ctl(ctl), .op_b(rb), .op_c(rc),
    .sts(sts), .res(alu_res)
  );

  // sequencer next state
  always_comb begin
    state_next    = state;
    ctl.start_mul = 1'b0;
    ctl.start_div = 1'b0;
    case (state)
      umx_pkg::S_IDLE:   if (in_valid) state_next = umx_pkg::S_DECODE;
      umx_pkg::S_DECODE: begin
        if (q_type == umx_pkg::T_INSN && op == umx_pkg::OP_MUL) begin
          ctl.start_mul = 1'b1;
          state_next = umx_pkg::S_MUL;
        end else if (q_type == umx_pkg::T_INSN && op == umx_pkg::OP_DIV && rc != '0) begin
          ctl.start_div = 1'b1;
          state_next = umx_pkg::S_DIV;
        end else begin
          state_next = umx_pkg::S_OUT;
        end
      end
      umx_pkg::S_MUL, umx_pkg::S_DIV: if (!sts.busy) state_next = umx_pkg::S_OUT;
      umx_pkg::S_OUT:    if (!out_stall) state_next = umx_pkg::S_IDLE;
      default:           state_next = umx_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= umx_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign in_stall  = (state != umx_pkg::S_IDLE);
  assign out_valid = (state == umx_pkg::S_OUT);

  // capture request
  always_ff @(posedge clk) begin
    if (state == umx_pkg::S_IDLE && in_valid) begin
      q_type <= req_type;
      q_insn <= instruction;
      q_rval <= return_value;
      q_eoi  <= end_of_input;
    end
  end

  // execute and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < umx_pkg::NumRegs; i++) regs[i] <= '0;
      pc           <= '0;
      pending_dest <= '0;
      pending_kind <= umx_pkg::P_NONE;
    end else if ((state == umx_pkg::S_MUL || state == umx_pkg::S_DIV) && !sts.busy) begin
      regs[ia] <= alu_res;
      pc <= pc + 1'b1;
    end else if (state == umx_pkg::S_DECODE) begin
      if (q_type != umx_pkg::T_INSN) begin
        if (pending_kind != umx_pkg::P_NONE && pending_kind == umx_pkg::pend_t'(q_type)) begin
          if (q_type == 2'(umx_pkg::P_INPUT))
            regs[pending_dest] <= q_eoi ? '1 : {24'd0, q_rval[7:0]};
          else
            regs[pending_dest] <= q_rval;
          pending_kind <= umx_pkg::P_NONE;
        end
      end else begin
        case (op)
          umx_pkg::OP_CMOV:  if (rc != '0) regs[ia] <= rb;
          umx_pkg::OP_LOAD:  begin
            pending_kind <= umx_pkg::P_LOAD;
            pending_dest <= ia;
          end
          umx_pkg::OP_ADD:   regs[ia] <= rb + rc;
          umx_pkg::OP_NAND:  regs[ia] <= ~(rb & rc);
          umx_pkg::OP_MAP:   begin
            pending_kind <= umx_pkg::P_MAP;
            pending_dest <= ib;
          end
          umx_pkg::OP_IN:    begin
            pending_kind <= umx_pkg::P_INPUT;
            pending_dest <= ic;
          end
          umx_pkg::OP_LOADI: regs[il] <= {7'd0, q_insn[24:0]};
          default: ;
        endcase
        // pc update; mul and a divide by a nonzero divisor advance on completion
        case (op)
          umx_pkg::OP_MUL, umx_pkg::OP_HALT, umx_pkg::OP_BAD0, umx_pkg::OP_BAD1: ;
          umx_pkg::OP_DIV:   ;
          umx_pkg::OP_LOADP: pc <= rc;
          default:           pc <= pc + 1'b1;
        endcase
      end
    end
  end

  // result register, built in decode
  always_ff @(posedge clk) begin
    if (state == umx_pkg::S_DECODE) begin
      req_kind    <= umx_pkg::K_NONE;
      seg_id      <= '0;
      word_offset <= '0;
      data_value  <= '0;
      next_pc     <= pc;
      if (q_type == umx_pkg::T_INSN) begin
        next_pc <= pc + 1'b1;
        case (op)
          umx_pkg::OP_LOAD:  begin
            req_kind <= umx_pkg::K_LOAD; seg_id <= rb; word_offset <= rc;
          end
          umx_pkg::OP_STORE: begin
            req_kind <= umx_pkg::K_STORE; seg_id <= ra; word_offset <= rb;
            data_value <= rc;
          end
          umx_pkg::OP_DIV:   if (rc == '0) begin
            req_kind <= umx_pkg::K_DIVZERO; next_pc <= pc;
          end
          umx_pkg::OP_HALT:  begin
            req_kind <= umx_pkg::K_HALT; next_pc <= pc;
          end
          umx_pkg::OP_MAP:   begin
            req_kind <= umx_pkg::K_MAP; data_value <= rc;
          end
          umx_pkg::OP_UNMAP: begin
            req_kind <= umx_pkg::K_UNMAP; seg_id <= rc;
          end
          umx_pkg::OP_OUT:   begin
            req_kind <= umx_pkg::K_OUTPUT; data_value <= {24'd0, rc[7:0]};
          end
          umx_pkg::OP_IN:    req_kind <= umx_pkg::K_INPUT;
          umx_pkg::OP_LOADP: begin
            req_kind <= umx_pkg::K_LOADPROG; seg_id <= rb; next_pc <= rc;
          end
          umx_pkg::OP_BAD0, umx_pkg::OP_BAD1: begin
            req_kind <= umx_pkg::K_BADOP; next_pc <= pc;
          end
          default: ;
        endcase
      end
    end
  end

  a_out_pc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |-> next_pc == pc) else $error("pc and result differ");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(req_kind))
    else $error("result changed under stall");
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == umx_pkg::S_IDLE || state == umx_pkg::S_OUT) |-> !sts.busy)
    else $error("unit busy outside multiply or divide");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives instruction and return requests into the universal machine executor
// and checks every result against a predictor that keeps its own registers,
// pc and pending request. Random sequences mix arithmetic with memory, map and
// input requests followed by their returns, plus stray returns and faults.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  rtype;
    logic [31:0] insn;
    logic [31:0] rval;
    logic        eoi;
  } req_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] seg;
    logic [31:0] off;
    logic [31:0] data;
    logic [31:0] npc;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [31:0] instruction = '0;
  logic [31:0] return_value = '0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  req_kind;
  logic [31:0] seg_id;
  logic [31:0] word_offset;
  logic [31:0] data_value;
  logic [31:0] next_pc;

  um_instruction_executor u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .instruction(instruction), .return_value(return_value),
    .end_of_input(end_of_input), .out_valid(out_valid), .out_stall(out_stall),
    .req_kind(req_kind), .seg_id(seg_id), .word_offset(word_offset),
    .data_value(data_value), .next_pc(next_pc)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // machine state copy
  logic [31:0]     regs [umx_pkg::NumRegs];
  logic [31:0]     pc_q;
  logic [2:0]      pend_dest;
  umx_pkg::pend_t  pend_kind;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   mismatches = 0;
  bit   quiet = 1'b0;
  int   hold_left = 0;

  // apply one request to the machine copy and return its result
  function automatic res_t execute(req_t r);
    res_t o;
    umx_pkg::op_t op;
    logic [2:0] a, b, c;
    logic [31:0] ra, rb, rc;
    o = '0;
    if (r.rtype != umx_pkg::T_INSN) begin
      if (pend_kind != umx_pkg::P_NONE && pend_kind == umx_pkg::pend_t'(r.rtype)) begin
        if (umx_pkg::pend_t'(r.rtype) == umx_pkg::P_INPUT)
          regs[pend_dest] = r.eoi ? 32'hFFFF_FFFF : {24'd0, r.rval[7:0]};
        else
          regs[pend_dest] = r.rval;
        pend_kind = umx_pkg::P_NONE;
      end
      o.kind = umx_pkg::K_NONE;
      o.npc = pc_q;
      return o;
    end
    op = umx_pkg::op_t'(r.insn[31:28]);
    a = r.insn[8:6];
    b = r.insn[5:3];
    c = r.insn[2:0];
    ra = regs[a];
    rb = regs[b];
    rc = regs[c];
    o.kind = umx_pkg::K_NONE;
    o.npc = pc_q + 32'd1;
    case (op)
      umx_pkg::OP_CMOV: if (rc != 0) regs[a] = rb;
      umx_pkg::OP_LOAD: begin
        o.kind = umx_pkg::K_LOAD; o.seg = rb; o.off = rc;
        pend_kind = umx_pkg::P_LOAD; pend_dest = a;
      end
      umx_pkg::OP_STORE: begin
        o.kind = umx_pkg::K_STORE; o.seg = ra; o.off = rb; o.data = rc;
      end
      umx_pkg::OP_ADD: regs[a] = rb + rc;
      umx_pkg::OP_MUL: regs[a] = rb * rc;
      umx_pkg::OP_DIV: begin
        if (rc == 0) begin
          o.kind = umx_pkg::K_DIVZERO; o.npc = pc_q;
        end else begin
          regs[a] = rb / rc;
        end
      end
      umx_pkg::OP_NAND: regs[a] = ~(rb & rc);
      umx_pkg::OP_HALT: begin
        o.kind = umx_pkg::K_HALT; o.npc = pc_q;
      end
      umx_pkg::OP_MAP: begin
        o.kind = umx_pkg::K_MAP; o.data = rc;
        pend_kind = umx_pkg::P_MAP; pend_dest = b;
      end
      umx_pkg::OP_UNMAP: begin
        o.kind = umx_pkg::K_UNMAP; o.seg = rc;
      end
      umx_pkg::OP_OUT: begin
        o.kind = umx_pkg::K_OUTPUT; o.data = {24'd0, rc[7:0]};
      end
      umx_pkg::OP_IN: begin
        o.kind = umx_pkg::K_INPUT;
        pend_kind = umx_pkg::P_INPUT; pend_dest = c;
      end
      umx_pkg::OP_LOADP: begin
        o.kind = umx_pkg::K_LOADPROG; o.seg = rb; o.npc = rc;
      end
      umx_pkg::OP_LOADI: regs[r.insn[27:25]] = {7'd0, r.insn[24:0]};
      default: begin
        o.kind = umx_pkg::K_BADOP; o.npc = pc_q;
      end
    endcase
    pc_q = o.npc;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [31:0] rand_insn(umx_pkg::op_t op);
    return {op, 28'($urandom_range(0, 2**28 - 1))};
  endfunction

  function automatic req_t mk(logic [1:0] t, logic [31:0] i, logic [31:0] v,
                              logic e);
    req_t r;
    r.rtype = t; r.insn = i; r.rval = v; r.eoi = e;
    return r;
  endfunction

  // random return word with a bias toward small and extreme values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // stall as seen at the last rising edge decides acceptance
  logic in_stall_q = 1'b0;
  logic in_acc = 1'b0;

  // driver: offer the next request, hold it while stalled
  int in_idle = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        void'(pending_reqs.pop_front());
      end
      if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        if (!(in_valid && in_stall_q)) in_valid <= 1'b0;
      end else if (in_valid && in_stall_q) begin
        in_valid <= 1'b1;
      end else if (pending_reqs.size() > 0) begin
        if (!quiet && $urandom_range(0, 19) == 0) begin
          in_valid <= 1'b0;
          in_idle <= $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b1;
          req_type <= pending_reqs[0].rtype;
          instruction <= pending_reqs[0].insn;
          return_value <= pending_reqs[0].rval;
          end_of_input <= pending_reqs[0].eoi;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
    in_acc <= in_valid && !in_stall && !rst;
    if (in_valid && !in_stall && !rst)
      expected_results.push_back(execute(mk(req_type, instruction,
                                            return_value, end_of_input)));
  end

  // receiver stall: random bursts plus one long hold-off
  int out_idle = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_idle > 0) begin
      out_idle <= out_idle - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      out_idle <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  res_t want;
  logic out_acc = 1'b0;
  always @(posedge clk) begin
    out_acc <= out_valid && !out_stall && !rst;
    if (out_valid && !out_stall && !rst) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", {28'd0, req_kind}, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (req_kind !== want.kind) report("req_kind", {28'd0, req_kind},
                                           {28'd0, want.kind});
        if (seg_id !== want.seg) report("seg_id", seg_id, want.seg);
        if (word_offset !== want.off) report("word_offset", word_offset, want.off);
        if (data_value !== want.data) report("data_value", data_value, want.data);
        if (next_pc !== want.npc) report("next_pc", next_pc, want.npc);
      end
    end
  end

  // watchdog on cycles without any handshake
  int stuck = 0;
  always @(posedge clk) begin
    if (in_acc || out_acc || rst) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > 5000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // directed part, then random sequences
  initial begin : stim
    int n;
    umx_pkg::op_t op;
    bit long_done;
    long_done = 1'b0;
    for (int i = 0; i < umx_pkg::NumRegs; i++) regs[i] = '0;
    pc_q = '0;
    pend_dest = '0;
    pend_kind = umx_pkg::P_NONE;
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // register extremes, every opcode, faults, stray and matching returns
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_LOADI, 3'd1, 25'h1FF_FFFF},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_NAND, 19'd0, 3'd2, 3'd0, 3'd0},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_DIV, 19'd0, 3'd3, 3'd1, 3'd0},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_DIV, 19'd0, 3'd3, 3'd2, 3'd1},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_MUL, 19'd0, 3'd4, 3'd2, 3'd2},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_ADD, 19'd0, 3'd5, 3'd2, 3'd1},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_CMOV, 19'd0, 3'd6, 3'd2, 3'd1},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_CMOV, 19'd0, 3'd7, 3'd2, 3'd0},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(2'(umx_pkg::P_LOAD), 32'd0, 32'hDEAD_BEEF, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_LOAD, 19'd0, 3'd7, 3'd2, 3'd1},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(2'(umx_pkg::P_MAP), 32'd0, 32'h1234_5678, 1'b0));
    pending_reqs.push_back(mk(2'(umx_pkg::P_LOAD), 32'd0, 32'hFFFF_FFFF, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_STORE, 19'd0, 3'd7, 3'd2, 3'd1},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_MAP, 19'd0, 3'd0, 3'd6, 3'd2},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(2'(umx_pkg::P_MAP), 32'd0, 32'h0000_0001, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_UNMAP, 19'd0, 3'd0, 3'd0, 3'd2},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_OUT, 19'd0, 3'd0, 3'd0, 3'd2},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_IN, 19'd0, 3'd0, 3'd0, 3'd3},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(2'(umx_pkg::P_INPUT), 32'd0, 32'hFFFF_FF41, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_IN, 19'd0, 3'd0, 3'd0, 3'd4},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(2'(umx_pkg::P_INPUT), 32'd0, 32'd0, 1'b1));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_HALT, 28'hFFF_FFFF},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_BAD0, 28'h0}, 32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_BAD1, 28'hFFF_FFFF},
                              32'd0, 1'b0));
    pending_reqs.push_back(mk(umx_pkg::T_INSN, {umx_pkg::OP_LOADP, 19'd0, 3'd0, 3'd0, 3'd2},
                              32'd0, 1'b0));

    // random: mostly instructions, with loads, maps and inputs followed by their matching return
    n = 0;
    while (n < 1350) begin
      while (pending_reqs.size() > 40) @(negedge clk);
      if (n >= 400 && !long_done) begin
        hold_left = 300;
        long_done = 1'b1;
      end
      if (n > 1150) quiet = 1'b1;
      op = umx_pkg::op_t'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(mk(2'($urandom_range(1, 3)), $urandom, rand_word(),
                                     1'($urandom_range(0, 1))));
        1: pending_reqs.push_back(mk(umx_pkg::T_INSN,
                                     {umx_pkg::OP_LOADI, 3'($urandom_range(0, 7)),
                                      25'(rand_word())}, 32'd0, 1'b0));
        default: begin
          pending_reqs.push_back(mk(umx_pkg::T_INSN, rand_insn(op), $urandom,
                                    1'($urandom)));
          if (op == umx_pkg::OP_LOAD || op == umx_pkg::OP_MAP || op == umx_pkg::OP_IN)
          begin
            n++;
            pending_reqs.push_back(mk(op == umx_pkg::OP_LOAD ? 2'(umx_pkg::P_LOAD) :
                                      op == umx_pkg::OP_MAP ? 2'(umx_pkg::P_MAP) :
                                      2'(umx_pkg::P_INPUT),
                                      $urandom, rand_word(),
                                      $urandom_range(0, 5) == 0));
          end
        end
      endcase
      n++;
    end
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
